### design/b64c_pkg.sv
// Shared types, constants and character functions for the base64url codec.
`timescale 1ns / 1ps

package b64c_pkg;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Padding character for a short final encode group.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Most output beats that one input item can cause.
    localparam int JOB_BEATS = 4;
    localparam int BEAT_IDX_W = $clog2(JOB_BEATS);
    localparam int BEAT_NUM_W = $clog2(JOB_BEATS + 1);

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Input beat payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output beat payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
    } t_out;

    // One job: the output beats caused by one input item.
    typedef struct packed {
        logic [JOB_BEATS-1:0][7:0] chars;
        logic [BEAT_NUM_W-1:0]     num;
        logic                      data_ok;
        logic                      end_msg;
    } t_job;

    // Queue status seen by the front end, the back end and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Maps a 6-bit value to its URL-safe alphabet character.
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26) begin
                c = 8'h41 + {2'b00, v};
            end else if (v < 6'd52) begin
                c = 8'h61 + {2'b00, v - 6'd26};
            end else if (v < 6'd62) begin
                c = 8'h30 + {2'b00, v - 6'd52};
            end else if (v == 6'd62) begin
                c = 8'h2D;
            end else begin
                c = 8'h5F;
            end
            return c;
        end
    endfunction

    // Maps a character to {known, value}; both alphabets' last two symbols are taken.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] r;
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                r = {1'b1, 6'(c - 8'h41)};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            end else if (c == 8'h2D || c == 8'h2B) begin
                r = {1'b1, 6'd62};
            end else if (c == 8'h5F || c == 8'h2F) begin
                r = {1'b1, 6'd63};
            end else begin
                r = 7'd0;
            end
            return r;
        end
    endfunction

endpackage

### design/b64c_front.sv
// Front end: accepts input beats, keeps the gathered bits and builds output jobs.
`timescale 1ns / 1ps

module b64c_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_in_valid,
    input  b64c_pkg::t_in   i_in_data,
    input  b64c_pkg::t_qstat i_qstat,
    output logic            o_in_stall,
    output logic            o_push,
    output b64c_pkg::t_job  o_job
);

    logic        r_dir;
    logic [15:0] r_bits;
    logic [2:0]  r_cnt;
    logic [15:0] n_bits;
    logic [2:0]  n_cnt;

    logic        w_take;
    logic [23:0] w_grp;
    logic [1:0]  w_have;
    logic [6:0]  w_sx;
    logic [5:0]  w_mask;
    logic [11:0] w_acc;
    logic [3:0]  w_hsum;
    logic [2:0]  w_new_held;

    // A full queue holds off the input side.
    assign o_in_stall = i_qstat.full;
    assign w_take     = i_in_valid && !i_qstat.full;

    // Decode path pieces: sextet lookup and accumulator.
    assign w_sx   = b64c_pkg::char_to_sextet(i_in_data.in_byte);
    assign w_mask = ~(6'h3F << r_cnt);
    assign w_acc  = {r_bits[5:0] & w_mask, w_sx[5:0]};
    assign w_hsum = {1'b0, r_cnt} + 4'd6;

    // Build the job for this beat and the next gathered state.
    always_comb begin
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        o_push     = 1'b0;
        o_job      = '0;
        w_grp      = '0;
        w_have     = 2'd1;
        w_new_held = 3'd0;
        if (r_dir == b64c_pkg::DIR_ENCODE) begin
            if (r_cnt >= 3'd2) begin
                w_grp  = {r_bits, i_in_data.in_byte};
                w_have = 2'd3;
            end else if (r_cnt == 3'd1) begin
                w_grp  = {r_bits[7:0], i_in_data.in_byte, 8'h00};
                w_have = 2'd2;
            end else begin
                w_grp  = {i_in_data.in_byte, 16'h0000};
                w_have = 2'd1;
            end
            if (w_have != 2'd3 && !i_in_data.in_last) begin
                n_bits = {r_bits[7:0], i_in_data.in_byte};
                n_cnt  = {1'b0, w_have};
            end else begin
                o_push           = 1'b1;
                o_job.chars[0]   = b64c_pkg::sextet_to_char(w_grp[23:18]);
                o_job.chars[1]   = b64c_pkg::sextet_to_char(w_grp[17:12]);
                o_job.chars[2]   = (w_have >= 2'd2) ?
                                   b64c_pkg::sextet_to_char(w_grp[11:6]) :
                                   b64c_pkg::PAD_CHAR;
                o_job.chars[3]   = (w_have == 2'd3) ?
                                   b64c_pkg::sextet_to_char(w_grp[5:0]) :
                                   b64c_pkg::PAD_CHAR;
                o_job.num        = b64c_pkg::BEAT_NUM_W'(b64c_pkg::JOB_BEATS);
                o_job.data_ok    = 1'b1;
                o_job.end_msg    = i_in_data.in_last;
                n_bits           = '0;
                n_cnt            = '0;
            end
        end else begin
            // Unknown, pad and line-break characters leave the state alone.
            if (w_sx[6]) begin
                if (w_hsum >= 4'd8) begin
                    w_new_held     = 3'(w_hsum - 4'd8);
                    o_push         = 1'b1;
                    o_job.chars[0] = 8'(w_acc >> (w_hsum - 4'd8));
                    o_job.num      = b64c_pkg::BEAT_NUM_W'(1);
                    o_job.data_ok  = 1'b1;
                    o_job.end_msg  = i_in_data.in_last;
                end else begin
                    w_new_held = 3'(w_hsum);
                end
                n_bits = {10'd0, w_acc[5:0] & ~(6'h3F << w_new_held)};
                n_cnt  = w_new_held;
            end
            if (i_in_data.in_last) begin
                // A last beat with no byte still ends the message.
                if (!o_push) begin
                    o_push        = 1'b1;
                    o_job.num     = b64c_pkg::BEAT_NUM_W'(1);
                    o_job.data_ok = 1'b0;
                    o_job.end_msg = 1'b1;
                end
                n_bits = '0;
                n_cnt  = '0;
            end
        end
        if (!w_take) begin
            o_push = 1'b0;
            n_bits = r_bits;
            n_cnt  = r_cnt;
        end
    end

    // Direction register and gathered state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= b64c_pkg::DIR_ENCODE;
            r_bits <= '0;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_dir  <= i_cfg_data;
            r_bits <= '0;
            r_cnt  <= '0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### design/b64c_queue.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module b64c_queue #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64c_pkg::t_job   i_job,
    input  logic             i_pop,
    output b64c_pkg::t_job   o_head,
    output b64c_pkg::t_qstat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64c_pkg::t_job r_slot [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_head       = r_slot[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/b64c_back.sv
// Back end: walks each job's beats into the registered output channel.
`timescale 1ns / 1ps

module b64c_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64c_pkg::t_job   i_head,
    input  b64c_pkg::t_qstat i_qstat,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output b64c_pkg::t_out   o_out_data
);

    b64c_pkg::t_job                  r_job;
    logic [b64c_pkg::BEAT_IDX_W-1:0] r_idx;
    logic                            r_busy;
    logic                            r_ovalid;
    b64c_pkg::t_out                  r_out;

    logic w_load;
    logic w_last_beat;

    // Move a beat whenever the output register is empty or being drained.
    assign w_load      = r_busy && (!r_ovalid || !i_out_stall);
    assign w_last_beat = ({1'b0, r_idx} == r_job.num - 1'b1);
    assign o_pop       = !i_qstat.empty && (!r_busy || (w_load && w_last_beat));

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Current job and beat index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_load) begin
            if (w_last_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte  <= r_job.chars[r_idx];
            r_out.out_valid <= r_job.data_ok;
            r_out.out_end   <= r_job.end_msg && w_last_beat;
        end
    end

endmodule

### design/base64url_codec.sv
// Top level of the streaming base64url encoder and decoder.
`timescale 1ns / 1ps

// Streaming base64url codec. Write the direction register (0 encode, 1 decode) while
// the block is idle; a write also drops any half-gathered group. The front end takes
// one input beat per cycle unless the queue is full and turns it into a job of zero
// to four output beats; a short job queue feeds the back end, which sends one output
// beat per cycle unless the receiver stalls, through a registered output stage.
// Decode therefore sustains one input beat per cycle without stalls. In encode every
// third byte, and every last byte, yields four characters, so the single output port
// paces a sustained encode stream.
module base64url_codec #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  logic           i_in_valid,
    input  b64c_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output b64c_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    logic             w_push;
    logic             w_pop;
    b64c_pkg::t_job   w_job;
    b64c_pkg::t_job   w_head;
    b64c_pkg::t_qstat w_qstat;

    b64c_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    b64c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // No output beat is pending right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job queue overflow");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job queue underflow");

    // A beat without data is always a bare end marker with a zero byte.
    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |->
            (o_out_data.out_end && o_out_data.out_byte == 8'h00))
        else $error("data-less beat is not an end marker");

endmodule

### sim/tb.sv
// Self-checking testbench for the base64url codec: random idling, a long hold-off, both directions.
`timescale 1ns / 1ps

module tb;

    // Cycles of quiet after the last result before the direction is rewritten.
    localparam int DRAIN_CYCLES = 10;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES = 80;

    // Characters that the decoder treats specially.
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;

    typedef enum bit {
        STIM_BEAT,
        STIM_CFG
    } t_stim_kind;

    typedef struct {
        t_stim_kind    kind;
        logic          cfg_val;
        b64c_pkg::t_in beat;
    } t_stim_entry;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          cfg_we_r = 1'b0;
    logic          cfg_val_r = 1'b0;
    logic          in_valid_r = 1'b0;
    b64c_pkg::t_in in_beat_r = '0;
    logic          out_stall_r = 1'b0;

    logic           o_in_stall;
    logic           o_out_valid;
    b64c_pkg::t_out o_out_data;

    string url_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // Pending stimulus and the output beats still owed by the block.
    t_stim_entry    stim_q[$];
    b64c_pkg::t_out codec_out_due[$];

    // Shadow of the codec state.
    logic        shadow_dir = b64c_pkg::DIR_ENCODE;
    logic [15:0] shadow_bits = '0;
    logic [2:0]  shadow_cnt = '0;

    int error_count = 0;
    int beats_planned = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int dir_writes = 0;

    int gap_left = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int stall_left = 0;
    int free_left = 0;

    base64url_codec u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we_r),
        .i_cfg_data  (cfg_val_r),
        .i_in_valid  (in_valid_r),
        .i_in_data   (in_beat_r),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall_r)
    );

    // Clock and the single reset at the start.
    always #6 clk = ~clk;

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] url_char(input logic [5:0] v);
        return url_alpha[int'(v)];
    endfunction

    // Six-bit value of a text character, or -1 when it is skipped.
    function automatic int char_val(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 65;
        if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 97 + 26;
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48 + 52;
        if (c == 8'h2D || c == PLUS_CHAR) return 62;
        if (c == 8'h5F || c == SLASH_CHAR) return 63;
        return -1;
    endfunction

    function automatic void owe_beat(input logic [7:0] b, input logic v, input logic e);
        b64c_pkg::t_out o;
        o.out_byte = b;
        o.out_valid = v;
        o.out_end = e;
        codec_out_due.insert(codec_out_due.size(), o);
    endfunction

    // Works out the output beats that one accepted input beat causes.
    function automatic void predict_codec_beat(input b64c_pkg::t_in beat);
        logic [23:0] grp;
        int          have;
        int          held;
        int          sv;
        logic [31:0] acc;
        bit          made;
        if (shadow_dir == b64c_pkg::DIR_ENCODE) begin
            if (shadow_cnt >= 3'd2) begin
                grp = {shadow_bits, beat.in_byte};
                have = 3;
            end else if (shadow_cnt == 3'd1) begin
                grp = {shadow_bits[7:0], beat.in_byte, 8'h00};
                have = 2;
            end else begin
                grp = {beat.in_byte, 16'h0000};
                have = 1;
            end
            if (have < 3 && !beat.in_last) begin
                // Keep gathering the group.
                shadow_bits = (have == 1) ? {8'h00, beat.in_byte}
                                          : {shadow_bits[7:0], beat.in_byte};
                shadow_cnt = 3'(have);
            end else begin
                owe_beat(url_char(grp[23:18]), 1'b1, 1'b0);
                owe_beat(url_char(grp[17:12]), 1'b1, 1'b0);
                owe_beat((have >= 2) ? url_char(grp[11:6]) : b64c_pkg::PAD_CHAR,
                         1'b1, 1'b0);
                owe_beat((have >= 3) ? url_char(grp[5:0]) : b64c_pkg::PAD_CHAR,
                         1'b1, beat.in_last);
                shadow_bits = '0;
                shadow_cnt = '0;
            end
        end else begin
            sv = char_val(beat.in_byte);
            made = 1'b0;
            if (sv >= 0) begin
                held = int'(shadow_cnt);
                acc = ((32'(shadow_bits) & ((32'd1 << held) - 32'd1)) << 6) | 32'(sv);
                held += 6;
                if (held >= 8) begin
                    owe_beat(8'(acc >> (held - 8)), 1'b1, beat.in_last);
                    made = 1'b1;
                    held -= 8;
                end
                shadow_bits = 16'(acc & ((32'd1 << held) - 32'd1));
                shadow_cnt = 3'(held);
            end
            if (beat.in_last) begin
                // A last beat always ends the message, with a bare marker if needed.
                if (!made) begin
                    owe_beat(8'h00, 1'b0, 1'b1);
                end
                shadow_bits = '0;
                shadow_cnt = '0;
            end
        end
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic last);
        t_stim_entry s;
        s.kind = STIM_BEAT;
        s.cfg_val = 1'b0;
        s.beat.in_byte = b;
        s.beat.in_last = last;
        stim_q.insert(stim_q.size(), s);
        beats_planned++;
    endtask

    task automatic add_cfg(input logic dir);
        t_stim_entry s;
        s.kind = STIM_CFG;
        s.cfg_val = dir;
        s.beat = '0;
        stim_q.insert(stim_q.size(), s);
    endtask

    // Messages of random length; decode text is mostly alphabet characters with some noise.
    task automatic add_random_phase(input logic dir, input int target);
        int          made;
        int          len;
        int          r;
        logic [7:0]  ch;
        add_cfg(dir);
        made = 0;
        while (made < target) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (dir == b64c_pkg::DIR_ENCODE) begin
                    ch = 8'($urandom_range(0, 255));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 80) begin
                        ch = url_alpha[$urandom_range(0, 63)];
                    end else if (r < 84) begin
                        ch = $urandom_range(0, 1) ? PLUS_CHAR : SLASH_CHAR;
                    end else if (r < 88) begin
                        ch = b64c_pkg::PAD_CHAR;
                    end else if (r < 92) begin
                        ch = $urandom_range(0, 1) ? CR_CHAR : LF_CHAR;
                    end else begin
                        ch = 8'($urandom_range(0, 255));
                    end
                end
                add_beat(ch, i == len - 1);
            end
            made += len;
        end
        // Sometimes leave a group half gathered for the next direction write to drop.
        if ($urandom_range(0, 3) == 0) begin
            add_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Stimulus plan, then the end of the run.
    initial begin
        int phase;

        // Encode: two-byte and one-byte padded groups, full groups, a dropped partial group.
        add_cfg(b64c_pkg::DIR_ENCODE);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b1);
        add_beat(8'hFB, 1'b1);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h80, 1'b1);
        add_beat(8'hFB, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'hBF, 1'b0);
        add_beat(8'h00, 1'b1);
        add_beat(8'h7F, 1'b0);

        // Decode: both symbol pairs, skipped characters, bare end markers, dropped bits.
        add_cfg(b64c_pkg::DIR_DECODE);
        add_beat(8'h41, 1'b0);
        add_beat(8'h5F, 1'b0);
        add_beat(SLASH_CHAR, 1'b0);
        add_beat(8'h2D, 1'b0);
        add_beat(b64c_pkg::PAD_CHAR, 1'b0);
        add_beat(CR_CHAR, 1'b0);
        add_beat(LF_CHAR, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(PLUS_CHAR, 1'b0);
        add_beat(8'h7A, 1'b0);
        add_beat(8'h39, 1'b1);
        add_beat(b64c_pkg::PAD_CHAR, 1'b1);
        add_beat(8'h51, 1'b0);
        add_beat(8'h55, 1'b1);
        add_beat(8'h5A, 1'b1);
        add_beat(8'h61, 1'b0);

        phase = 0;
        while (beats_planned < 310) begin
            add_random_phase((phase % 2 == 0) ? b64c_pkg::DIR_ENCODE : b64c_pkg::DIR_DECODE,
                             40);
            phase++;
        end

        while (stim_q.size() != 0 || in_valid_r || codec_out_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input beats and checked %0d output beats across %0d direction writes.",
                 beats_sent, beats_checked, dir_writes);
        $display("Covered padded groups, skipped characters, bare end markers and a long hold-off.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Input driver: offers queued beats with random gaps and rewrites the direction when idle.
    always @(posedge clk) begin
        logic          nv;
        b64c_pkg::t_in nd;
        logic          nwe;
        logic          ncv;
        bit            took;
        int            r;
        if (!rst_n) begin
            in_valid_r <= 1'b0;
            in_beat_r <= '0;
            cfg_we_r <= 1'b0;
            cfg_val_r <= 1'b0;
            gap_left = 0;
            quiet_cycles = 0;
        end else begin
            nv = in_valid_r;
            nd = in_beat_r;
            nwe = 1'b0;
            ncv = cfg_val_r;
            took = 1'b0;
            if (in_valid_r && !o_in_stall) begin
                predict_codec_beat(in_beat_r);
                beats_sent++;
                nv = 1'b0;
                took = 1'b1;
            end
            if (took || cfg_we_r || codec_out_due.size() != 0) begin
                quiet_cycles = 0;
            end else if (quiet_cycles < DRAIN_CYCLES) begin
                quiet_cycles++;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() != 0) begin
                    if (stim_q[0].kind == STIM_CFG) begin
                        if (quiet_cycles >= DRAIN_CYCLES) begin
                            nwe = 1'b1;
                            ncv = stim_q[0].cfg_val;
                            shadow_dir = stim_q[0].cfg_val;
                            shadow_bits = '0;
                            shadow_cnt = '0;
                            dir_writes++;
                            quiet_cycles = 0;
                            void'(stim_q.pop_front());
                        end
                    end else begin
                        nv = 1'b1;
                        nd = stim_q[0].beat;
                        void'(stim_q.pop_front());
                        // Gap before the next beat: mostly short, a few long, some bursts.
                        if (burst_left > 0) begin
                            burst_left--;
                            gap_left = 0;
                        end else begin
                            r = $urandom_range(0, 99);
                            if (r < 50) begin
                                gap_left = 0;
                            end else if (r < 80) begin
                                gap_left = $urandom_range(1, 2);
                            end else if (r < 93) begin
                                gap_left = $urandom_range(3, 8);
                            end else if (r < 97) begin
                                gap_left = $urandom_range(15, 40);
                            end else begin
                                gap_left = 0;
                                burst_left = $urandom_range(15, 40);
                            end
                        end
                    end
                end
            end
            in_valid_r <= nv;
            in_beat_r <= nd;
            cfg_we_r <= nwe;
            cfg_val_r <= ncv;
        end
    end

    // Output monitor: checks each accepted beat and drives the receiver stall.
    always @(posedge clk) begin
        logic           nst;
        b64c_pkg::t_out want;
        int             r;
        if (!rst_n) begin
            out_stall_r <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall_r) begin
                if (codec_out_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected output beat, expected none, got byte=%02h valid=%0b end=%0b",
                             $time, o_out_data.out_byte, o_out_data.out_valid,
                             o_out_data.out_end);
                end else begin
                    want = codec_out_due.pop_front();
                    if (o_out_data.out_byte !== want.out_byte ||
                        o_out_data.out_valid !== want.out_valid ||
                        o_out_data.out_end !== want.out_end) begin
                        error_count++;
                        $display("%0t: mismatch, expected byte=%02h valid=%0b end=%0b, got byte=%02h valid=%0b end=%0b",
                                 $time, want.out_byte, want.out_valid, want.out_end,
                                 o_out_data.out_byte, o_out_data.out_valid,
                                 o_out_data.out_end);
                    end
                end
                beats_checked++;
                // Long hold-off so the block backs up into its input.
                if (beats_checked % 350 == 40) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                nst = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nst = 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                nst = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    nst = 1'b0;
                end else if (r < 85) begin
                    nst = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 93) begin
                    nst = 1'b1;
                    stall_left = $urandom_range(5, 20);
                end else begin
                    nst = 1'b0;
                    free_left = $urandom_range(20, 60);
                end
            end
            out_stall_r <= nst;
        end
    end

endmodule
